>>> design/sed_pkg.sv
// shared types, constants and helpers of the segment edge deduplicator
package sed_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int COORD_BITS_DEF = 21;
	localparam int SLOT_W = 6;
	localparam int USED_W = 7;
	localparam int ADDR_W = 4;

	localparam logic [31:0] INV_EPS_RST = 32'd65536000;
	localparam logic REPL_EN_RST = 1'b1;
	localparam logic [31:0] PRIO_RST = 32'd1985229328;

	localparam logic [ADDR_W-1:0] REG_INV_EPS = 4'h0;
	localparam logic [ADDR_W-1:0] REG_REPL_EN = 4'h4;
	localparam logic [ADDR_W-1:0] REG_PRIO = 4'h8;

	typedef enum logic [2:0] {
		OUT_NEW = 3'd0,
		OUT_REPLACED = 3'd1,
		OUT_DROPPED = 3'd2,
		OUT_FULL = 3'd3,
		OUT_CLEARED = 3'd4
	} outcome_t;

	typedef struct packed {
		logic action;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
		logic [2:0] edge_type;
	} seg_in_t;

	typedef struct packed {
		logic [2:0] outcome;
		logic [SLOT_W-1:0] slot;
		logic [USED_W-1:0] entries_used;
	} seg_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUANT,
		ST_ORDER,
		ST_SCAN,
		ST_CHECK,
		ST_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic quant;
		logic order;
		logic scan_start;
		logic scan_step;
		logic check;
		logic write_new;
		logic write_type;
		logic clear;
		logic out_load;
		logic [2:0] outcome;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_clear;
		logic coord_done;
		logic scan_end;
		logic hit;
		logic better;
		logic full;
	} dp_stat_t;

	function automatic logic [3:0] prio_of(input logic [31:0] prios, input logic [2:0] t);
		return prios[{t, 2'b00} +: 4];
	endfunction

endpackage

>>> design/segment_edge_deduplicator_unit.sv
// top level of the segment edge deduplicator
// a segment passes quantise, order, a scan and check per slot compared (hit slot + 1,
// else used_count, at least 1) and result; a clear goes straight to result
// throughput: one item at a time, the next taken in the cycle after its result is loaded,
// set by the six-coordinate shared multiplier and the one-port key table scan
// reset: used_count, control state and registers return to reset values;
// table contents are undefined until written
module segment_edge_deduplicator_unit #(
	parameter int TABLE_DEPTH = sed_pkg::TABLE_DEPTH_DEF,
	parameter int COORD_BITS = sed_pkg::COORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sed_pkg::seg_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output sed_pkg::seg_out_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [sed_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import sed_pkg::*;

	logic [31:0] inv_eps_q, prio_q;
	logic repl_en_q;
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_eps_q <= INV_EPS_RST;
			repl_en_q <= REPL_EN_RST;
			prio_q <= PRIO_RST;
		end else if (wr) begin
			case (paddr)
				REG_INV_EPS: inv_eps_q <= pwdata;
				REG_REPL_EN: repl_en_q <= pwdata[0];
				REG_PRIO: prio_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			REG_INV_EPS: prdata = inv_eps_q;
			REG_REPL_EN: prdata = {31'd0, repl_en_q};
			REG_PRIO: prdata = prio_q;
			default: prdata = '0;
		endcase
	end

	sed_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	sed_dp #(.TABLE_DEPTH(TABLE_DEPTH), .COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .cmd(cmd),
		.inv_eps(inv_eps_q), .repl_en(repl_en_q), .prios(prio_q),
		.stat(stat), .out_data(out_data)
	);

	// a new entry never lands on a full table
	assert property (@(posedge clk) disable iff (!arst_n) cmd.write_new |-> !stat.full)
		else $error("write into full table");
	// a cleared result reports an empty table
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && cmd.clear |=> out_data.entries_used == '0 && out_data.slot == '0)
		else $error("clear result not empty");
	// no new item while the previous is still in flight
	assert property (@(posedge clk) disable iff (!arst_n) cmd.load |=> !in_ready)
		else $error("item taken while busy");
endmodule

>>> design/sed_ram.sv
// generic single-port ram with registered read
module sed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

>>> design/sed_ctrl.sv
// sequencer for quantise, order, table scan and result
module sed_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input sed_pkg::dp_stat_t stat,
	output sed_pkg::dp_cmd_t cmd
);
	import sed_pkg::*;

	state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.outcome = OUT_NEW;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_QUANT;
				end
			end
			ST_QUANT: begin
				if (stat.is_clear) begin
					state_d = ST_RESULT;
				end else begin
					cmd.quant = 1'b1;
					if (stat.coord_done) begin
						state_d = ST_ORDER;
					end
				end
			end
			ST_ORDER: begin
				cmd.order = 1'b1;
				cmd.scan_start = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				// ram read of the issued slot lands next cycle
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (!stat.scan_end && !stat.hit) begin
					cmd.scan_step = 1'b1;
					state_d = ST_SCAN;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
					if (stat.is_clear) begin
						cmd.outcome = OUT_CLEARED;
						cmd.clear = 1'b1;
					end else if (stat.hit) begin
						if (stat.better) begin
							cmd.outcome = OUT_REPLACED;
							cmd.write_type = 1'b1;
						end else begin
							cmd.outcome = OUT_DROPPED;
						end
					end else if (stat.full) begin
						cmd.outcome = OUT_FULL;
					end else begin
						cmd.outcome = OUT_NEW;
						cmd.write_new = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

>>> design/sed_dp.sv
// datapath: quantiser, key order, key table and result register
module sed_dp #(
	parameter int TABLE_DEPTH = sed_pkg::TABLE_DEPTH_DEF,
	parameter int COORD_BITS = sed_pkg::COORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input sed_pkg::seg_in_t in_data,
	input sed_pkg::dp_cmd_t cmd,
	input logic [31:0] inv_eps,
	input logic repl_en,
	input logic [31:0] prios,
	output sed_pkg::dp_stat_t stat,
	output sed_pkg::seg_out_t out_data
);
	import sed_pkg::*;

	localparam int KEY_W = 3 * COORD_BITS;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [31:0] CMAX = 32'((64'd1 << (COORD_BITS - 1)) - 64'd1);
	localparam logic [31:0] CNEG = 32'(64'd1 << (COORD_BITS - 1));

	seg_in_t item_q;
	logic [2:0] ci_q;
	logic [COORD_BITS-1:0] coord_q [6];
	logic [KEY_W-1:0] klo_q, khi_q;
	logic [CNT_W-1:0] used_q, scan_q;
	logic hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	seg_out_t out_q;

	// one coordinate per cycle through the shared multiplier
	logic [31:0] raw, mag;
	logic neg;
	logic [63:0] prod;
	logic [32:0] r;
	logic [COORD_BITS-1:0] qv;

	always_comb begin
		case (ci_q)
			3'd0: raw = item_q.start_x;
			3'd1: raw = item_q.start_y;
			3'd2: raw = item_q.start_z;
			3'd3: raw = item_q.end_x;
			3'd4: raw = item_q.end_y;
			default: raw = item_q.end_z;
		endcase
		neg = raw[31];
		mag = neg ? (~raw + 32'd1) : raw;
		prod = 64'(mag) * 64'(inv_eps);
		r = 33'((65'(prod) + 65'h80000000) >> 32);
		if (neg) begin
			qv = (r >= 33'(CNEG)) ? COORD_BITS'(CNEG) : COORD_BITS'(~r + 33'd1);
		end else begin
			qv = (r > 33'(CMAX)) ? COORD_BITS'(CMAX) : COORD_BITS'(r);
		end
	end

	// lexicographic signed compare of the endpoints
	logic a_le_b;
	logic [KEY_W-1:0] ka, kb;
	always_comb begin
		ka = {coord_q[0], coord_q[1], coord_q[2]};
		kb = {coord_q[3], coord_q[4], coord_q[5]};
		if (coord_q[0] != coord_q[3]) begin
			a_le_b = $signed(coord_q[0]) < $signed(coord_q[3]);
		end else if (coord_q[1] != coord_q[4]) begin
			a_le_b = $signed(coord_q[1]) < $signed(coord_q[4]);
		end else begin
			a_le_b = $signed(coord_q[2]) <= $signed(coord_q[5]);
		end
	end

	logic [IDX_W-1:0] raddr, addr;
	logic [KEY_W-1:0] rd_lo, rd_hi;
	logic [2:0] rd_type, type_q;
	logic key_we, type_we;

	assign raddr = scan_q[IDX_W-1:0];
	assign key_we = cmd.write_new;
	assign type_we = cmd.write_new || cmd.write_type;
	assign addr = cmd.write_new ? used_q[IDX_W-1:0] : (cmd.write_type ? hit_idx_q : raddr);

	sed_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_lo (
		.clk(clk), .we(key_we), .addr(addr), .wdata(klo_q), .rdata(rd_lo)
	);
	sed_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_hi (
		.clk(clk), .we(key_we), .addr(addr), .wdata(khi_q), .rdata(rd_hi)
	);
	sed_ram #(.WIDTH(3), .DEPTH(TABLE_DEPTH)) u_type (
		.clk(clk), .we(type_we), .addr(addr), .wdata(item_q.edge_type), .rdata(rd_type)
	);

	logic match;
	assign match = (scan_q < used_q) && (rd_lo == klo_q) && (rd_hi == khi_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.quant) begin
			coord_q[ci_q] <= qv;
		end
		if (cmd.order) begin
			klo_q <= a_le_b ? ka : kb;
			khi_q <= a_le_b ? kb : ka;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q <= '0;
			used_q <= '0;
			scan_q <= '0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			type_q <= '0;
			out_q <= '0;
		end else begin
			if (cmd.load) begin
				ci_q <= '0;
			end else if (cmd.quant) begin
				ci_q <= ci_q + 3'd1;
			end
			if (cmd.scan_start) begin
				scan_q <= '0;
				hit_q <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			// the check state sees the ram data of scan_q
			if (cmd.check && !hit_q && match) begin
				hit_q <= 1'b1;
				hit_idx_q <= raddr;
				type_q <= rd_type;
			end
			if (cmd.clear) begin
				used_q <= '0;
			end else if (cmd.write_new) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_q.outcome <= cmd.outcome;
				if (cmd.clear) begin
					out_q.slot <= '0;
					out_q.entries_used <= '0;
				end else if (cmd.write_new) begin
					out_q.slot <= SLOT_W'(used_q);
					out_q.entries_used <= USED_W'(used_q + CNT_W'(1));
				end else begin
					out_q.slot <= hit_q ? SLOT_W'(hit_idx_q) : '0;
					out_q.entries_used <= USED_W'(used_q);
				end
			end
		end
	end

	assign stat.is_clear = item_q.action;
	assign stat.coord_done = (ci_q == 3'd5);
	assign stat.scan_end = (scan_q + CNT_W'(1) >= used_q) || match;
	assign stat.hit = hit_q || match;
	assign stat.better = repl_en && (prio_of(prios, item_q.edge_type) < prio_of(prios, type_q));
	assign stat.full = (used_q == CNT_W'(TABLE_DEPTH));
	assign out_data = out_q;
endmodule

>>> tb/sv/testbench.sv
// self-checking testbench of the segment edge deduplicator unit
`timescale 1ns / 1ps

module testbench;
	import sed_pkg::*;

	localparam int DEPTH = 64;
	localparam int QMAX = (1 << 20) - 1;
	localparam int QMIN = -(1 << 20);

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	seg_in_t in_data;
	logic out_valid;
	logic out_ready;
	seg_out_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	segment_edge_deduplicator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the configuration and the key table
	logic [31:0] inv_eps_sh;
	logic repl_en_sh;
	logic [31:0] prio_sh;
	logic [62:0] low_key_sh [DEPTH];
	logic [62:0] high_key_sh [DEPTH];
	logic [2:0] holder_sh [DEPTH];
	int used_sh;

	seg_in_t pending_segs [$];
	seg_out_t expected_results [$];
	seg_in_t recent_segs [$];
	int accepted_cnt;
	int error_cnt;
	int hold_cycles;
	bit hold_done;
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("segment_edge_deduplicator_unit regression: fail");
		$finish;
	end

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_cnt++;
	endtask

	function automatic int quantize(input logic [31:0] raw);
		logic [31:0] mag;
		logic [63:0] prod;
		logic [63:0] r;
		mag = raw[31] ? -raw : raw;
		prod = {32'b0, mag} * {32'b0, inv_eps_sh};
		r = (prod + 64'h8000_0000) >> 32;
		if (raw[31]) begin
			if (r >= 64'(-QMIN))
				return QMIN;
			return -int'(r);
		end
		if (r > 64'(QMAX))
			return QMAX;
		return int'(r);
	endfunction

	function automatic seg_out_t dedup_step(input seg_in_t s);
		seg_out_t o;
		int a [3];
		int b [3];
		logic [62:0] ka;
		logic [62:0] kb;
		logic [62:0] klo;
		logic [62:0] khi;
		bit a_first;
		o = '0;
		if (s.action) begin
			used_sh = 0;
			o.outcome = OUT_CLEARED;
			return o;
		end
		a[0] = quantize(s.start_x);
		a[1] = quantize(s.start_y);
		a[2] = quantize(s.start_z);
		b[0] = quantize(s.end_x);
		b[1] = quantize(s.end_y);
		b[2] = quantize(s.end_z);
		if (a[0] != b[0])
			a_first = a[0] < b[0];
		else if (a[1] != b[1])
			a_first = a[1] < b[1];
		else
			a_first = a[2] <= b[2];
		ka = {a[0][20:0], a[1][20:0], a[2][20:0]};
		kb = {b[0][20:0], b[1][20:0], b[2][20:0]};
		klo = a_first ? ka : kb;
		khi = a_first ? kb : ka;
		for (int i = 0; i < used_sh; i++) begin
			if (low_key_sh[i] == klo && high_key_sh[i] == khi) begin
				if (repl_en_sh && prio_sh[4*s.edge_type +: 4] < prio_sh[4*holder_sh[i] +: 4]) begin
					holder_sh[i] = s.edge_type;
					o.outcome = OUT_REPLACED;
				end else begin
					o.outcome = OUT_DROPPED;
				end
				o.slot = i[SLOT_W-1:0];
				o.entries_used = used_sh[USED_W-1:0];
				return o;
			end
		end
		if (used_sh >= DEPTH) begin
			o.outcome = OUT_FULL;
			o.entries_used = used_sh[USED_W-1:0];
			return o;
		end
		low_key_sh[used_sh] = klo;
		high_key_sh[used_sh] = khi;
		holder_sh[used_sh] = s.edge_type;
		o.outcome = OUT_NEW;
		o.slot = used_sh[SLOT_W-1:0];
		used_sh++;
		o.entries_used = used_sh[USED_W-1:0];
		return o;
	endfunction

	// driver: one transfer per handshake, payload held until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results = {expected_results, dedup_step(in_data)};
				accepted_cnt++;
			end
			if (!in_valid || in_ready) begin
				if (pending_segs.size() > 0 && (quiet || $urandom_range(99) >= 29)) begin
					in_data <= pending_segs.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stall control
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cycles = 0;
			hold_done = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report("result with nothing expected");
				end else begin
					seg_out_t e;
					e = expected_results.pop_front();
					if (out_data.outcome !== e.outcome)
						report($sformatf("outcome %0d, expected %0d", out_data.outcome, e.outcome));
					if (out_data.slot !== e.slot)
						report($sformatf("slot %0d, expected %0d", out_data.slot, e.slot));
					if (out_data.entries_used !== e.entries_used)
						report($sformatf("entries_used %0d, expected %0d",
							out_data.entries_used, e.entries_used));
				end
			end
			if (!hold_done && accepted_cnt >= 300) begin
				hold_done = 1;
				hold_cycles = 1500;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || $urandom_range(99) >= 29;
			end
		end
	end

	always @(posedge clk)
		quiet <= accepted_cnt >= 600 && accepted_cnt < 800;

	task automatic reg_write(input logic [ADDR_W-1:0] a, input logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (a)
			REG_INV_EPS: inv_eps_sh = d;
			REG_REPL_EN: repl_en_sh = d[0];
			REG_PRIO: prio_sh = d;
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (pending_segs.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	task automatic queue_seg(input seg_in_t s);
		pending_segs = {pending_segs, s};
	endtask

	function automatic seg_in_t mk(input logic act, input logic [31:0] sx, input logic [31:0] sy,
			input logic [31:0] sz, input logic [31:0] ex, input logic [31:0] ey,
			input logic [31:0] ez, input logic [2:0] t);
		seg_in_t s;
		s.action = act;
		s.start_x = sx;
		s.start_y = sy;
		s.start_z = sz;
		s.end_x = ex;
		s.end_y = ey;
		s.end_z = ez;
		s.edge_type = t;
		return s;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
		endcase
	endfunction

	// mostly fresh or repeated segments, an occasional clear
	task automatic add_random(input int n, input int clear_pct);
		seg_in_t s;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < clear_pct) begin
				s = mk(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					3'($urandom));
			end else if (recent_segs.size() > 0 && $urandom_range(99) < 45) begin
				s = recent_segs[$urandom_range(recent_segs.size() - 1)];
				if ($urandom_range(1))
					s = mk(1'b0, s.end_x, s.end_y, s.end_z, s.start_x, s.start_y, s.start_z, 3'b0);
				s.edge_type = 3'($urandom);
			end else begin
				s = mk(1'b0, rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), 3'($urandom));
				recent_segs = {recent_segs, s};
				if (recent_segs.size() > 24)
					void'(recent_segs.pop_front());
			end
			queue_seg(s);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		accepted_cnt = 0;
		error_cnt = 0;
		quiet = 0;
		inv_eps_sh = INV_EPS_RST;
		repl_en_sh = REPL_EN_RST;
		prio_sh = PRIO_RST;
		used_sh = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: priority of a type is the type itself
		queue_seg(mk(1'b0, 0, 0, 0, 32'h1_0000, 0, 0, 3'd5));
		queue_seg(mk(1'b0, 32'h1_0000, 0, 0, 0, 0, 0, 3'd7));
		queue_seg(mk(1'b0, 32'h1_0000, 0, 0, 0, 0, 0, 3'd2));
		queue_seg(mk(1'b0, 0, 0, 0, 32'h1_0000, 0, 0, 3'd2));
		queue_seg(mk(1'b0, 0, 0, 0, 32'h1_0000, 0, 0, 3'd0));
		queue_seg(mk(1'b0, 32'h3_0000, 32'h3_0000, 32'h3_0000,
			32'h3_0000, 32'h3_0000, 32'h3_0000, 3'd0));
		queue_seg(mk(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3'd4));
		queue_seg(mk(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_0000, 32'h7fff_0000, 32'h7fff_0000, 3'd1));
		queue_seg(mk(1'b0, 5, 7, 32'hffff_fff0, 5, 7, 32'h10, 3'd3));
		queue_seg(mk(1'b0, 5, 7, 32'h10, 5, 7, 32'hffff_fff0, 3'd6));
		queue_seg(mk(1'b0, 32'h2_0000, 32'hfffe_0000, 0, 32'h2_0000, 32'h2_0000, 0, 3'd3));
		queue_seg(mk(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 3'd7));
		queue_seg(mk(1'b0, 0, 0, 0, 32'h1_0000, 0, 0, 3'd7));
		add_random(220, 2);
		drain();

		// unit step: halves round away from zero
		reg_write(REG_INV_EPS, 32'h0001_0000);
		reg_write(REG_REPL_EN, 32'h1);
		reg_write(REG_PRIO, $urandom);
		queue_seg(mk(1'b0, 32'h8000, 32'hffff_8000, 32'h1_8000,
			32'h1_0000, 32'hffff_0000, 32'h2_0000, 3'd1));
		queue_seg(mk(1'b0, 32'h7fff, 32'hffff_8001, 32'h1_7fff,
			32'h0, 32'h0, 32'h1_0000, 3'd2));
		queue_seg(mk(1'b0, 32'h0, 32'h0, 32'h1_0000,
			32'h7fff, 32'hffff_8001, 32'h1_7fff, 3'd0));
		add_random(260, 1);
		drain();

		// zero reciprocal collapses every segment onto one key
		reg_write(REG_INV_EPS, 32'h0);
		reg_write(REG_PRIO, 32'h0123_4567);
		add_random(120, 3);
		drain();

		// largest reciprocal, replacement off
		reg_write(REG_INV_EPS, 32'hffff_ffff);
		reg_write(REG_REPL_EN, 32'h0);
		reg_write(REG_PRIO, 32'h0);
		add_random(240, 2);
		drain();

		reg_write(REG_INV_EPS, $urandom_range(1 << 24));
		reg_write(REG_REPL_EN, 32'h1);
		reg_write(REG_PRIO, 32'hffff_ffff);
		add_random(200, 2);
		drain();

		// no clears for a while, so the table fills
		reg_write(REG_INV_EPS, INV_EPS_RST);
		reg_write(REG_PRIO, PRIO_RST);
		add_random(300, 0);
		drain();

		if (error_cnt == 0 && expected_results.size() == 0) begin
			$display("segment_edge_deduplicator_unit regression: pass");
		end else begin
			$display("segment_edge_deduplicator_unit regression: fail");
		end
		$finish;
	end

endmodule
